[sv/assert_macros.svh]
// Assertion helpers for the RTL. The clock is clk and the reset is arst_n in every user.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define ASSERT_IMPLIES(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, checked outside reset.
`define ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[sv/tfs_pkg.sv]
package tfs_pkg;

	localparam logic [7:0] CHAR_CR    = 8'h0D;
	localparam logic [7:0] CHAR_LF    = 8'h0A;
	localparam logic [7:0] CHAR_QUOTE = 8'h22;
	localparam logic [7:0] CHAR_COMMA = 8'h2C;
	localparam logic [7:0] SEP_RESET  = 8'h09;

	// Parser states. The two unused codes behave as line start.
	typedef enum logic [2:0] {
		ST_LINE     = 3'd0,
		ST_AFTER_CR = 3'd1,
		ST_FIELD    = 3'd2,
		ST_PLAIN    = 3'd3,
		ST_QUOTED   = 3'd4,
		ST_QSEEN    = 3'd5
	} parse_state_t;

	typedef enum logic [1:0] {
		K_DATA       = 2'd0,
		K_FIELD_END  = 2'd1,
		K_RECORD_END = 2'd2,
		K_EMPTY      = 2'd3
	} kind_t;

	typedef struct packed {
		logic [7:0] in_byte;
		logic       end_of_input;
	} in_item_t;

	typedef struct packed {
		logic [7:0] out_byte;
		kind_t      kind;
	} res_t;

	// Parser verdict for the item in the input register.
	typedef struct packed {
		logic emit;
		res_t res;
	} parse_out_t;

endpackage

[sv/tfs_in_reg.sv]
module tfs_in_reg
	import tfs_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       s_axis_tvalid,
	output logic       s_axis_tready,
	input  logic [7:0] s_axis_tdata,
	input  logic       s_axis_tuser,
	input  logic       advance,
	output logic       item_valid,
	output in_item_t   item
);

	logic     valid_s1;
	in_item_t item_s1;
	logic     load;

	// The slot frees up in the same cycle its item moves on.
	assign s_axis_tready = !valid_s1 || advance;
	assign load          = s_axis_tvalid && s_axis_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (load) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			item_s1.in_byte      <= s_axis_tdata;
			item_s1.end_of_input <= s_axis_tuser;
		end
	end

	assign item_valid = valid_s1;
	assign item       = item_s1;

endmodule

[sv/tfs_parser.sv]
module tfs_parser
	import tfs_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cfg_we,
	input  logic [7:0] cfg_wdata,
	input  in_item_t   item,
	input  logic       advance,
	output parse_out_t pout
);

	parse_state_t state_q;
	parse_state_t state_nxt;
	parse_state_t eff_state;
	logic [7:0]   separator_q;
	logic [7:0]   b;
	logic         line_start;
	logic         is_sep;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			separator_q <= SEP_RESET;
		end else if (cfg_we) begin
			separator_q <= cfg_wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_LINE;
		end else if (advance) begin
			state_q <= state_nxt;
		end
	end

	assign b      = item.in_byte;
	assign is_sep = (b == separator_q);

	always_comb begin
		case (state_q)
			ST_FIELD, ST_PLAIN, ST_QUOTED, ST_QSEEN: line_start = 1'b0;
			default:                                 line_start = 1'b1;
		endcase
	end

	always_comb begin
		state_nxt         = state_q;
		pout.emit         = 1'b0;
		pout.res.out_byte = 8'h00;
		pout.res.kind     = K_DATA;
		eff_state         = line_start ? ST_FIELD : state_q;

		if (item.end_of_input) begin
			state_nxt     = ST_LINE;
			pout.emit     = !line_start;
			pout.res.kind = K_RECORD_END;
		end else if (state_q == ST_AFTER_CR && b == CHAR_LF) begin
			// Second half of a CR LF pair.
			state_nxt = ST_LINE;
		end else if (b == CHAR_CR || b == CHAR_LF) begin
			// Line ends win over the separator.
			state_nxt     = (b == CHAR_CR) ? ST_AFTER_CR : ST_LINE;
			pout.emit     = 1'b1;
			pout.res.kind = line_start ? K_EMPTY : K_RECORD_END;
		end else begin
			case (eff_state)
				ST_FIELD: begin
					if (b == CHAR_QUOTE || b == CHAR_COMMA) begin
						state_nxt = ST_QUOTED;
					end else if (is_sep) begin
						state_nxt     = ST_FIELD;
						pout.emit     = 1'b1;
						pout.res.kind = K_FIELD_END;
					end else begin
						state_nxt         = ST_PLAIN;
						pout.emit         = 1'b1;
						pout.res.out_byte = b;
					end
				end
				ST_QUOTED: begin
					if (b == CHAR_QUOTE) begin
						state_nxt = ST_QSEEN;
					end else begin
						state_nxt         = ST_QUOTED;
						pout.emit         = 1'b1;
						pout.res.out_byte = b;
					end
				end
				ST_QSEEN: begin
					if (b == CHAR_QUOTE) begin
						// Doubled quote stands for one literal quote.
						state_nxt         = ST_QUOTED;
						pout.emit         = 1'b1;
						pout.res.out_byte = b;
					end else if (is_sep) begin
						state_nxt     = ST_FIELD;
						pout.emit     = 1'b1;
						pout.res.kind = K_FIELD_END;
					end else begin
						state_nxt         = ST_PLAIN;
						pout.emit         = 1'b1;
						pout.res.out_byte = b;
					end
				end
				default: begin
					if (is_sep) begin
						state_nxt     = ST_FIELD;
						pout.emit     = 1'b1;
						pout.res.kind = K_FIELD_END;
					end else begin
						state_nxt         = ST_PLAIN;
						pout.emit         = 1'b1;
						pout.res.out_byte = b;
					end
				end
			endcase
		end
	end

endmodule

[sv/tfs_out_reg.sv]
module tfs_out_reg
	import tfs_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       load,
	input  res_t       res,
	output logic       can_load,
	output logic       m_axis_tvalid,
	input  logic       m_axis_tready,
	output logic [7:0] m_axis_tdata,
	output logic [1:0] m_axis_tuser
);

	logic valid_s2;
	res_t res_s2;

	assign can_load = !valid_s2 || m_axis_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (load) begin
			valid_s2 <= 1'b1;
		end else if (m_axis_tready) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			res_s2 <= res;
		end
	end

	assign m_axis_tvalid = valid_s2;
	assign m_axis_tdata  = res_s2.out_byte;
	assign m_axis_tuser  = res_s2.kind;

endmodule

[sv/tsv_field_splitter.sv]
// Channel       Direction  tdata (low bit up)   tuser (low bit up)
// s_axis        in         in_byte [7:0]        end_of_input [0]
// m_axis        out        out_byte [7:0]       kind [1:0]
// cfg_we/wdata  in         separator [7:0]      -
//
// Each item waits in the input register and then its result moves to the result register, so
// a result shows on m_axis from the result register, after its item has left the input
// register; one item per cycle is sustained while m_axis_tready stays high, set by the
// single-step parser state update between those two registers.
// Reset (arst_n low) empties both registers, returns the parser to line start and loads
// the separator with tab. A stalled m_axis holds its result; the input register still takes
// one more item, after which s_axis_tready follows m_axis_tready.
`include "assert_macros.svh"

module tsv_field_splitter
	import tfs_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	// Separator register write.
	input  logic       cfg_we,
	input  logic [7:0] cfg_wdata,
	// Input items.
	input  logic       s_axis_tvalid,
	output logic       s_axis_tready,
	input  logic [7:0] s_axis_tdata,   // [7:0] in_byte
	input  logic       s_axis_tuser,   // [0] end_of_input
	// Result items.
	output logic       m_axis_tvalid,
	input  logic       m_axis_tready,
	output logic [7:0] m_axis_tdata,   // [7:0] out_byte
	output logic [1:0] m_axis_tuser    // [1:0] kind
);

	logic       item_valid;
	in_item_t   item;
	logic       can_load;
	logic       advance;
	logic       out_load;
	parse_out_t pout;

	// The held item is parsed once the result register has room for whatever it produces.
	// Items that produce nothing (swallowed LF, opening quote) move on just the same.
	assign advance  = item_valid && can_load;
	assign out_load = advance && pout.emit;

	tfs_in_reg u_in_reg (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.advance       (advance),
		.item_valid    (item_valid),
		.item          (item)
	);

	// The parser state only steps when an item actually leaves the input register.
	tfs_parser u_parser (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.item      (item),
		.advance   (advance),
		.pout      (pout)
	);

	tfs_out_reg u_out_reg (
		.clk           (clk),
		.arst_n        (arst_n),
		.load          (out_load),
		.res           (pout.res),
		.can_load      (can_load),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser)
	);

	// Marker results never carry a byte.
	`ASSERT_IMPLIES(a_marker_zero, m_axis_tvalid && (m_axis_tuser != K_DATA), m_axis_tdata == 8'h00, "marker result with nonzero byte")
	// A new item is only taken into a free or draining input register.
	`ASSERT_IMPLIES(a_in_slot_free, s_axis_tvalid && s_axis_tready, !item_valid || advance, "input register overrun")
	// A result is never written over one still waiting downstream.
	`ASSERT_IMPLIES(a_out_no_overwrite, out_load, !m_axis_tvalid || m_axis_tready, "result register overrun")
	// A stalled item in the input register stays there.
	`ASSERT_NEXT(a_hold_item, item_valid && !can_load, item_valid, "input item lost while stalled")

endmodule
